// ===== rtl/uts_pkg.sv =====
// Shared types and constants for the UTF-8 text summary scanner.
package uts_pkg;

    // Configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_ROW_ORIGIN = 1'b0;   // register index carried in paddr[2]

    // Decoder constants
    localparam int unsigned CP_W     = 21;
    localparam logic [CP_W-1:0] NEWLINE_CP = 21'h00000A;
    localparam logic [CP_W-1:0] BMP_MAX    = 21'h00FFFF;

    // Front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified byte request, as handed from front to back
    typedef struct packed {
        logic byte_present;   // a byte was carried
        logic cp_valid;       // a code point completed on this byte
        logic is_nl;          // completed code point is a newline
        logic wide;           // completed code point needs a surrogate pair
        logic last;           // closes the text
    } uts_event_t;

endpackage

// ===== rtl/utf8_text_summary_scan.sv =====
// Top level of the UTF-8 text summary scanner.
// Takes a text one byte request per cycle and, after the request marked last,
// presents one summary: byte, character, UTF-16 unit and newline counts, the
// character counts of the first and last lines, and the length and row
// (row_origin plus local row) of the longest line, first one winning ties.
// Sequences are decoded from the lead byte; continuation bytes are not
// checked. A bad lead byte freezes every count except bytes until the text
// ends. All counts saturate at MAX_TEXT_BYTES. A request with byte_valid low
// and last high closes a text, possibly empty; with last low it is ignored.
// Throughput is one byte per cycle. The front end decodes into a four-entry
// event queue; the back end updates counters one event per cycle and passes
// a closed text through the snapshot stage to the output register, which
// drives summary_valid. Input keeps flowing while a summary waits: the back
// end only stalls on an end of text that finds both the snapshot stage and
// the output register full, and input stalls only once the queue has filled.
// row_origin (byte address 0) may be written only while the block is idle.
module utf8_text_summary_scan #(
    parameter longint unsigned MAX_TEXT_BYTES = 64'd16777216
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // byte requests
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         byte_valid,
    input  logic                         last,
    // summary
    output logic                         summary_valid,
    input  logic                         summary_ready,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] total_bytes,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] total_chars,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] utf16_units,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] newline_rows,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] head_line_chars,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] tail_line_chars,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0] longest_line_chars,
    output logic [(($clog2(MAX_TEXT_BYTES+1) > 32) ?
                   $clog2(MAX_TEXT_BYTES+1) : 32):0] longest_line_row,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uts_pkg::PADDR_W-1:0]  paddr,
    input  logic [uts_pkg::PDATA_W-1:0]  pwdata,
    output logic [uts_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import uts_pkg::*;

    localparam int unsigned CW = $clog2(MAX_TEXT_BYTES+1);
    localparam int unsigned RW = ((CW > 32) ? CW : 32) + 1;

    logic [31:0] row_origin_reg;
    logic        reg_sel;
    logic        q_full, q_valid, push, pop;
    uts_event_t  push_ev, q_ev;

    // config register: index lives in paddr[2], byte lanes ignored
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_ROW_ORIGIN);
    assign prdata  = reg_sel ? row_origin_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_origin_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            row_origin_reg <= pwdata;
        end
    end

    uts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .q_full     (q_full),
        .push       (push),
        .push_ev    (push_ev)
    );

    uts_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ev (push_ev),
        .full    (q_full),
        .q_valid (q_valid),
        .q_ev    (q_ev),
        .pop     (pop)
    );

    uts_back #(
        .CW             (CW),
        .RW             (RW),
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_ev               (q_ev),
        .pop                (pop),
        .row_origin         (row_origin_reg),
        .summary_valid      (summary_valid),
        .summary_ready      (summary_ready),
        .total_bytes        (total_bytes),
        .total_chars        (total_chars),
        .utf16_units        (utf16_units),
        .newline_rows       (newline_rows),
        .head_line_chars    (head_line_chars),
        .tail_line_chars    (tail_line_chars),
        .longest_line_chars (longest_line_chars),
        .longest_line_row   (longest_line_row)
    );

endmodule

// ===== rtl/uts_front.sv =====
// Front end: accepts byte requests and decodes UTF-8 sequences into events.
module uts_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [7:0]         data_byte,
    input  logic               byte_valid,
    input  logic               last,
    input  logic               q_full,
    output logic               push,
    output uts_pkg::uts_event_t push_ev
);
    import uts_pkg::*;

    logic [1:0]      seq_rem_reg, seq_rem_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic            halted_reg, halted_next;
    logic [CP_W-1:0] cp;

    assign item_ready = !q_full;
    assign push       = item_valid && item_ready;

    always_comb
    begin
        push_ev              = '0;
        push_ev.byte_present = byte_valid;
        push_ev.last         = last;
        cp                   = '0;
        seq_rem_next         = seq_rem_reg;
        partial_next         = partial_reg;
        halted_next          = halted_reg;

        if (byte_valid && !halted_reg)
        begin
            if (seq_rem_reg == 2'd0)
            begin
                unique casez (data_byte)
                    8'b0???????:
                    begin
                        cp               = {13'd0, data_byte};
                        push_ev.cp_valid = 1'b1;
                    end
                    8'b110?????:
                    begin
                        partial_next = {16'd0, data_byte[4:0]};
                        seq_rem_next = 2'd1;
                    end
                    8'b1110????:
                    begin
                        partial_next = {17'd0, data_byte[3:0]};
                        seq_rem_next = 2'd2;
                    end
                    8'b11110???:
                    begin
                        partial_next = {18'd0, data_byte[2:0]};
                        seq_rem_next = 2'd3;
                    end
                    default:
                    begin
                        halted_next = 1'b1;   // stray continuation or bad lead
                    end
                endcase
            end
            else
            begin
                partial_next = {partial_reg[CP_W-7:0], data_byte[5:0]};
                seq_rem_next = seq_rem_reg - 2'd1;
                if (seq_rem_reg == 2'd1)
                begin
                    cp               = partial_next;
                    push_ev.cp_valid = 1'b1;
                end
            end
        end

        push_ev.is_nl = (cp == NEWLINE_CP);
        push_ev.wide  = (cp > BMP_MAX);

        // decoder starts clean on the next text
        if (last)
        begin
            seq_rem_next = 2'd0;
            partial_next = '0;
            halted_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_rem_reg <= 2'd0;
            partial_reg <= '0;
            halted_reg  <= 1'b0;
        end
        else if (push)
        begin
            seq_rem_reg <= seq_rem_next;
            partial_reg <= partial_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

// ===== rtl/uts_queue.sv =====
// Short event queue between front end and back end.
module uts_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  uts_pkg::uts_event_t push_ev,
    output logic                full,
    output logic                q_valid,
    output uts_pkg::uts_event_t q_ev,
    input  logic                pop
);
    import uts_pkg::*;

    uts_event_t      mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_ev    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/uts_back.sv =====
// Back end: saturating counters, end-of-text snapshot and summary register.
module uts_back #(
    parameter int unsigned CW = 25,
    parameter int unsigned RW = 33,
    parameter longint unsigned MAX_TEXT_BYTES = 64'd16777216
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  uts_pkg::uts_event_t q_ev,
    output logic                pop,
    input  logic [31:0]         row_origin,
    output logic                summary_valid,
    input  logic                summary_ready,
    output logic [CW-1:0]       total_bytes,
    output logic [CW-1:0]       total_chars,
    output logic [CW-1:0]       utf16_units,
    output logic [CW-1:0]       newline_rows,
    output logic [CW-1:0]       head_line_chars,
    output logic [CW-1:0]       tail_line_chars,
    output logic [CW-1:0]       longest_line_chars,
    output logic [RW-1:0]       longest_line_row
);
    import uts_pkg::*;

    localparam logic [CW-1:0] CAP = CW'(MAX_TEXT_BYTES);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
        sat_inc = (a >= CAP) ? CAP : a + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sat_add2(input logic [CW-1:0] a);
        sat_add2 = (a >= CAP - 1'b1) ? CAP : a + CW'(2);
    endfunction

    // running text state
    logic [CW-1:0] byte_reg, char_reg, unit_reg, row_reg, line_reg, first_reg;
    logic [CW-1:0] best_reg, brow_reg;
    logic          seen_reg;
    logic [CW-1:0] byte_upd, char_upd, unit_upd, row_upd, line_upd, first_upd;
    logic [CW-1:0] best_upd, brow_upd;
    logic          seen_upd;

    // snapshot of a closed text
    logic          snap_valid_reg;
    logic [CW-1:0] snap_bytes_reg, snap_chars_reg, snap_units_reg, snap_rows_reg;
    logic [CW-1:0] snap_first_reg, snap_line_reg, snap_best_reg, snap_brow_reg;
    logic          snap_take, snap_free;

    // summary register
    logic          out_valid_reg;
    logic [CW-1:0] out_bytes_reg, out_chars_reg, out_units_reg, out_rows_reg;
    logic [CW-1:0] out_first_reg, out_line_reg, out_best_reg;
    logic [RW-1:0] out_row_reg;
    logic          use_final;

    assign snap_take = snap_valid_reg && (!out_valid_reg || summary_ready);
    assign snap_free = !snap_valid_reg || snap_take;
    assign pop       = q_valid && (!q_ev.last || snap_free);

    always_comb
    begin
        byte_upd  = byte_reg;
        char_upd  = char_reg;
        unit_upd  = unit_reg;
        row_upd   = row_reg;
        line_upd  = line_reg;
        first_upd = first_reg;
        best_upd  = best_reg;
        brow_upd  = brow_reg;
        seen_upd  = seen_reg;

        if (q_ev.byte_present)
        begin
            byte_upd = sat_inc(byte_reg);
        end
        if (q_ev.cp_valid)
        begin
            char_upd = sat_inc(char_reg);
            unit_upd = q_ev.wide ? sat_add2(unit_reg) : sat_inc(unit_reg);
            if (q_ev.is_nl)
            begin
                if (!seen_reg)
                begin
                    first_upd = line_reg;
                end
                seen_upd = 1'b1;
                if (line_reg > best_reg)
                begin
                    best_upd = line_reg;
                    brow_upd = row_reg;
                end
                row_upd  = sat_inc(row_reg);
                line_upd = '0;
            end
            else
            begin
                line_upd = sat_inc(line_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= '0;
            char_reg  <= '0;
            unit_reg  <= '0;
            row_reg   <= '0;
            line_reg  <= '0;
            first_reg <= '0;
            best_reg  <= '0;
            brow_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (pop)
        begin
            if (q_ev.last)
            begin
                byte_reg  <= '0;
                char_reg  <= '0;
                unit_reg  <= '0;
                row_reg   <= '0;
                line_reg  <= '0;
                first_reg <= '0;
                best_reg  <= '0;
                brow_reg  <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                byte_reg  <= byte_upd;
                char_reg  <= char_upd;
                unit_reg  <= unit_upd;
                row_reg   <= row_upd;
                line_reg  <= line_upd;
                first_reg <= first_upd;
                best_reg  <= best_upd;
                brow_reg  <= brow_upd;
                seen_reg  <= seen_upd;
            end
        end
    end

    // snapshot stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (pop && q_ev.last)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_ev.last)
        begin
            snap_bytes_reg <= byte_upd;
            snap_chars_reg <= char_upd;
            snap_units_reg <= unit_upd;
            snap_rows_reg  <= row_upd;
            snap_first_reg <= seen_upd ? first_upd : line_upd;
            snap_line_reg  <= line_upd;
            snap_best_reg  <= best_upd;
            snap_brow_reg  <= brow_upd;
        end
    end

    // final line competes too; with no newline it is the only line
    assign use_final = (snap_line_reg > snap_best_reg) || (snap_rows_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (summary_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            out_bytes_reg <= snap_bytes_reg;
            out_chars_reg <= snap_chars_reg;
            out_units_reg <= snap_units_reg;
            out_rows_reg  <= snap_rows_reg;
            out_first_reg <= snap_first_reg;
            out_line_reg  <= snap_line_reg;
            out_best_reg  <= use_final ? snap_line_reg : snap_best_reg;
            out_row_reg   <= RW'(row_origin)
                           + RW'(use_final ? snap_rows_reg : snap_brow_reg);
        end
    end

    assign summary_valid      = out_valid_reg;
    assign total_bytes        = out_bytes_reg;
    assign total_chars        = out_chars_reg;
    assign utf16_units        = out_units_reg;
    assign newline_rows       = out_rows_reg;
    assign head_line_chars    = out_first_reg;
    assign tail_line_chars    = out_line_reg;
    assign longest_line_chars = out_best_reg;
    assign longest_line_row   = out_row_reg;

endmodule

// ===== rtl/uts_checker.sv =====
// Port-level checks on the summary channel, bound to the top level.
module uts_checker #(
    parameter int unsigned CW = 25
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          summary_valid,
    input logic          summary_ready,
    input logic [CW-1:0] total_bytes,
    input logic [CW-1:0] total_chars,
    input logic [CW-1:0] utf16_units,
    input logic [CW-1:0] newline_rows,
    input logic [CW-1:0] head_line_chars,
    input logic [CW-1:0] tail_line_chars,
    input logic [CW-1:0] longest_line_chars
);

    // a stalled summary holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid && !summary_ready |=> summary_valid && $stable(total_bytes))
        else $error("summary dropped or changed while stalled");

    // every character takes at least one byte; newlines are characters
    a_chars: assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid |-> (total_chars <= total_bytes) && (newline_rows <= total_chars))
        else $error("character count exceeds byte count");

    // one or two UTF-16 units per character
    a_units: assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid |-> (utf16_units >= total_chars)
                          && ({1'b0, utf16_units} <= {total_chars, 1'b0}))
        else $error("UTF-16 unit count out of range");

    // the longest line is at least as long as the first and the last
    a_longest: assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid |-> (longest_line_chars >= head_line_chars)
                          && (longest_line_chars >= tail_line_chars))
        else $error("longest line shorter than first or last line");

endmodule

bind utf8_text_summary_scan uts_checker #(
    .CW ($clog2(MAX_TEXT_BYTES+1))
) u_uts_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .summary_valid      (summary_valid),
    .summary_ready      (summary_ready),
    .total_bytes        (total_bytes),
    .total_chars        (total_chars),
    .utf16_units        (utf16_units),
    .newline_rows       (newline_rows),
    .head_line_chars    (head_line_chars),
    .tail_line_chars    (tail_line_chars),
    .longest_line_chars (longest_line_chars)
);
